/* hdl/tftt_pkg.sv */
`timescale 1ns / 1ps
package tftt_pkg;

	localparam int FRAME_LEN = 7;
	localparam int CNT_W = 3;
	localparam logic [7:0] HDR_BYTE = 8'h68;
	localparam logic [7:0] TRL_BYTE = 8'hFF;
	localparam logic [15:0] IDLE_MAX = 16'hFFFF;
	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd5000;
	localparam logic [7:0] MOVE_THRESHOLD_RST = 8'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic CFG_IDLE_TIMEOUT = 1'b0;
	localparam logic CFG_MOVE_THRESHOLD = 1'b1;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ERASE = 2'd1,
		ACT_DRAW  = 2'd2
	} action_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} touch_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} burst_t;

endpackage

/* hdl/tftt_if.sv */
`timescale 1ns / 1ps
interface tftt_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface tftt_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               last;

	modport source (output valid, output action, output pos_x, output pos_y,
		output last, input ready);
	modport sink (input valid, input action, input pos_x, input pos_y,
		input last, output ready);
endinterface

/* hdl/tftt_parser.sv */
`timescale 1ns / 1ps
module tftt_parser
	import tftt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output touch_t     touch
);

	logic             in_frame_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       frame_q [FRAME_LEN-1];
	logic             frame_end;

	// the final trailer byte is the current one and is never stored
	assign frame_end = in_frame_q && (byte_count_q == CNT_W'(FRAME_LEN - 1));

	assign touch.hit = fire && frame_end && (frame_q[4] == TRL_BYTE)
		&& (frame_q[5] == TRL_BYTE) && (rx_byte == TRL_BYTE);
	assign touch.x = {frame_q[1], frame_q[0]};
	assign touch.y = {frame_q[3], frame_q[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			byte_count_q <= '0;
		end else if (fire) begin
			if (!in_frame_q) begin
				if (rx_byte == HDR_BYTE) begin
					in_frame_q <= 1'b1;
					byte_count_q <= '0;
				end
			end else if (frame_end) begin
				in_frame_q <= 1'b0;
				byte_count_q <= '0;
			end else begin
				byte_count_q <= byte_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_frame_q && !frame_end) begin
			frame_q[byte_count_q] <= rx_byte;
		end
	end

endmodule

/* hdl/tftt_trail.sv */
`timescale 1ns / 1ps
module tftt_trail
	import tftt_pkg::*;
#(
	parameter int TRAIL_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  touch_t      touch,
	input  logic [15:0] idle_timeout_ms,
	input  logic [7:0]  move_threshold,
	output burst_t      burst
);

	logic signed [15:0] trail_x_q [TRAIL_LEN];
	logic signed [15:0] trail_y_q [TRAIL_LEN];
	logic [TRAIL_LEN-1:0] valid_q;
	logic [15:0] idle_q;
	logic        drawn_q;

	logic [15:0] idle_inc;
	logic        clear;
	logic [16:0] dx, dy, adx, ady;
	logic        near;
	logic        add;

	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign clear = tick && drawn_q && (idle_inc > idle_timeout_ms);

	// full precision distance to the newest dot
	assign dx = {touch.x[15], touch.x} - {trail_x_q[TRAIL_LEN-1][15], trail_x_q[TRAIL_LEN-1]};
	assign dy = {touch.y[15], touch.y} - {trail_y_q[TRAIL_LEN-1][15], trail_y_q[TRAIL_LEN-1]};
	assign adx = dx[16] ? -dx : dx;
	assign ady = dy[16] ? -dy : dy;
	assign near = valid_q[TRAIL_LEN-1] && (adx <= {9'd0, move_threshold})
		&& (ady <= {9'd0, move_threshold});
	assign add = touch.hit && !near;

	always_comb begin
		burst.n = 2'd0;
		burst.r0 = '{action: ACT_CLEAR, x: '0, y: '0, last: 1'b1};
		burst.r1 = '{action: ACT_DRAW, x: touch.x, y: touch.y, last: 1'b1};
		if (clear) begin
			burst.n = 2'd1;
		end else if (add) begin
			if (valid_q[0]) begin
				burst.n = 2'd2;
				burst.r0 = '{action: ACT_ERASE, x: trail_x_q[0], y: trail_y_q[0],
					last: 1'b0};
			end else begin
				burst.n = 2'd1;
				burst.r0 = '{action: ACT_DRAW, x: touch.x, y: touch.y, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idle_q <= '0;
			drawn_q <= 1'b0;
		end else if (tick) begin
			idle_q <= idle_inc;
			if (clear) begin
				drawn_q <= 1'b0;
				valid_q <= '0;
			end
		end else if (touch.hit) begin
			idle_q <= '0;
			drawn_q <= 1'b1;
			if (add) begin
				valid_q <= {1'b1, valid_q[TRAIL_LEN-1:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add) begin
			for (int i = 0; i < TRAIL_LEN - 1; i++) begin
				trail_x_q[i] <= trail_x_q[i+1];
				trail_y_q[i] <= trail_y_q[i+1];
			end
			trail_x_q[TRAIL_LEN-1] <= touch.x;
			trail_y_q[TRAIL_LEN-1] <= touch.y;
		end
	end

endmodule

/* hdl/tftt_outbuf.sv */
`timescale 1ns / 1ps
module tftt_outbuf
	import tftt_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  burst_t         burst,
	output logic           room,
	tftt_result_if.source  result
);

	result_t    slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && result.ready;
	// a new burst of up to two words fits once the buffer drains this cycle
	assign room = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result.ready);

	assign result.valid = (cnt_q != 2'd0);
	assign result.action = slot0_q.action;
	assign result.pos_x = slot0_q.x;
	assign result.pos_y = slot0_q.y;
	assign result.last = slot0_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && room) begin
			cnt_q <= burst.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && room) begin
			slot0_q <= burst.r0;
			slot1_q <= burst.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

/* hdl/touch_frame_trail_tracker_core.sv */
`timescale 1ns / 1ps
// touch frame trail tracker
// item channel: opcode 0 carries a received byte, opcode 1 a one millisecond
// tick. frames are 0x68, x and y as little-endian signed 16-bit values, then
// three 0xFF trailer bytes; a bad trailer drops the frame silently.
// result channel: clear, erase or draw words with coordinates; last marks
// the final word caused by one item (an erase of the oldest dot may precede
// a draw when the trail is full).
// cfg port: cfg_we writes cfg_data into register cfg_index
// (0 idle timeout in ticks, 1 per-axis move threshold); the user must write
// only while idle, the block itself does not enforce this. an item taken is
// registered in the input register, then in the output buffer. one item per
// cycle while the result side keeps up; one that gives two words holds the
// next item until the two-word buffer, draining one word per cycle, has room.
// a result stalled by the receiver stays in the buffer and one more item is
// held in the input register; then item.ready drops.
// reset empties the trail, clears the idle counter and the frame hunt and
// loads the register defaults; no clearing pass is needed.
module touch_frame_trail_tracker_core
	import tftt_pkg::*;
#(
	parameter int TRAIL_LEN = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	tftt_item_if.sink     item,
	tftt_result_if.source result,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);

	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  byte_s1;
	logic        adv_s1;
	logic        room;
	logic [15:0] idle_timeout_q;
	logic [7:0]  move_threshold_q;
	touch_t      touch;
	burst_t      burst;

	assign adv_s1 = valid_s1 && room;
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1 <= item.opcode;
			byte_s1 <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= IDLE_TIMEOUT_RST;
			move_threshold_q <= MOVE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data;
				CFG_MOVE_THRESHOLD: move_threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tftt_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv_s1 && (opcode_s1 == OP_BYTE)),
		.rx_byte (byte_s1),
		.touch   (touch)
	);

	tftt_trail #(
		.TRAIL_LEN (TRAIL_LEN)
	) u_trail (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick            (adv_s1 && (opcode_s1 == OP_TICK)),
		.touch           (touch),
		.idle_timeout_ms (idle_timeout_q),
		.move_threshold  (move_threshold_q),
		.burst           (burst)
	);

	tftt_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv_s1),
		.burst  (burst),
		.room   (room),
		.result (result)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |-> !item.ready)
		else $error("item taken while input register is blocked");

	a_burst_n: assert property (@(posedge clk) disable iff (!arst_n)
		burst.n != 2'd3)
		else $error("more than two result words for one item");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(burst.n == 2'd2) |-> (burst.r0.action == ACT_ERASE
		&& burst.r1.action == ACT_DRAW && !burst.r0.last))
		else $error("two-word burst is not erase then draw");

	a_touch_vs_tick: assert property (@(posedge clk) disable iff (!arst_n)
		touch.hit |-> (adv_s1 && opcode_s1 == OP_BYTE))
		else $error("touch reported without an advancing byte");

endmodule
